// ===== sv/tcp_option_finder_defines.svh =====
// ----------------------------------------------------------------------------
// tcp_option_finder_defines.svh
// Assertion macros used by the option finder parser.
// ----------------------------------------------------------------------------
`ifndef TCP_OPTION_FINDER_DEFINES_SVH
`define TCP_OPTION_FINDER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define TOF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define TOF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tof_pkg.sv =====
// ----------------------------------------------------------------------------
// tof_pkg
// Shared types and constants for the TCP option finder.
// ----------------------------------------------------------------------------
package tof_pkg;

  // Default sizing
  localparam int MAX_OPTION_BYTES = 40;
  localparam int VALUE_BITS       = 64;

  // Option header length (kind + length bytes) and bits per byte
  localparam logic [7:0] HDR_LEN   = 8'd2;
  localparam int         BYTE_BITS = 8;

  // Search result codes
  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_NODATA = 2'd1,
    ST_DATA   = 2'd2
  } status_t;

  // One option-area byte with its side information
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] wanted_kind;
  } item_t;

endpackage

// ===== sv/tof_in_stage.sv =====
// ----------------------------------------------------------------------------
// tof_in_stage
// Input register: holds one accepted byte until the parser takes it.
// ----------------------------------------------------------------------------
module tof_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_valid,
  output logic           s_ready,
  input  tof_pkg::item_t s_item,
  output logic           item_valid,
  output tof_pkg::item_t item,
  input  logic           item_take
);

  logic load;

  // Free when empty or when the held byte leaves this cycle
  assign s_ready = !item_valid || item_take;
  assign load    = s_valid && s_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= load || (item_valid && !item_take);
    end
    if (load) begin
      item <= s_item;
    end
  end

endmodule

// ===== sv/tof_parser.sv =====
// ----------------------------------------------------------------------------
// tof_parser
// Kind-length walker over the option area with the result register.
// ----------------------------------------------------------------------------
`include "tcp_option_finder_defines.svh"

module tof_parser #(
  parameter int MAX_OPTION_BYTES = tof_pkg::MAX_OPTION_BYTES,
  parameter int VALUE_BITS       = tof_pkg::VALUE_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  tof_pkg::item_t item,
  output logic           item_take,
  output logic           res_valid,
  input  logic           res_ready,
  output logic [1:0]     res_status,
  output logic [63:0]    res_value
);

  localparam int OFFSET_W = $clog2(MAX_OPTION_BYTES + 1);

  typedef enum logic [1:0] {
    PH_KIND = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  // Walker state
  phase_t               phase;
  logic [OFFSET_W-1:0]  area_offset;
  logic                 kind_hit;
  logic [7:0]           bytes_left;
  logic [7:0]           target_kind;
  logic [VALUE_BITS-1:0] value_accum;
  tof_pkg::status_t     search_status;

  // Next values
  phase_t               phase_next;
  logic [OFFSET_W-1:0]  area_offset_next;
  logic                 kind_hit_next;
  logic [7:0]           bytes_left_next;
  logic [7:0]           target_kind_next;
  logic [VALUE_BITS-1:0] value_accum_next;
  tof_pkg::status_t     search_status_next;

  logic [VALUE_BITS+7:0] shifted;
  logic [7:0]            b;
  logic                  out_free;

  assign b         = item.data_byte;
  assign out_free  = !res_valid || res_ready;
  // A last byte needs room in the result register
  assign item_take = item_valid && (!item.last_byte || out_free);

  // Per-byte update: restart on a first byte, then one step of the walk
  always_comb begin
    if (item.first_byte) begin
      phase_next         = PH_KIND;
      area_offset_next   = '0;
      kind_hit_next      = 1'b0;
      bytes_left_next    = '0;
      value_accum_next   = '0;
      search_status_next = tof_pkg::ST_NONE;
      target_kind_next   = item.wanted_kind;
    end else begin
      phase_next         = phase;
      area_offset_next   = area_offset;
      kind_hit_next      = kind_hit;
      bytes_left_next    = bytes_left;
      value_accum_next   = value_accum;
      search_status_next = search_status;
      target_kind_next   = target_kind;
    end

    shifted = {value_accum_next, b};

    if (area_offset_next >= OFFSET_W'(MAX_OPTION_BYTES)) begin
      // past the option area: an open option never fits
      if (phase_next != PH_DONE && search_status_next == tof_pkg::ST_NONE) begin
        phase_next = PH_DONE;
      end
    end else begin
      case (phase_next)
        PH_KIND: begin
          if (b > 8'd1) begin
            kind_hit_next = (b == target_kind_next) && (target_kind_next > 8'd1);
            phase_next    = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b < tof_pkg::HDR_LEN) begin
            // bad length reads as a no-op byte
            kind_hit_next = 1'b0;
            phase_next    = PH_KIND;
          end else if (kind_hit_next && b == tof_pkg::HDR_LEN) begin
            search_status_next = tof_pkg::ST_NODATA;
            phase_next         = PH_DONE;
          end else begin
            bytes_left_next  = b - tof_pkg::HDR_LEN;
            value_accum_next = '0;
            phase_next       = (b == tof_pkg::HDR_LEN) ? PH_KIND : PH_DATA;
          end
        end
        PH_DATA: begin
          if (kind_hit_next) begin
            value_accum_next = shifted[VALUE_BITS-1:0];
          end
          bytes_left_next = bytes_left_next - 8'd1;
          if (bytes_left_next == 8'd0) begin
            if (kind_hit_next) begin
              search_status_next = tof_pkg::ST_DATA;
              phase_next         = PH_DONE;
            end else begin
              phase_next = PH_KIND;
            end
          end
        end
        default: begin
        end
      endcase
      area_offset_next = area_offset_next + 1'b1;
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_KIND;
      area_offset   <= '0;
      kind_hit      <= 1'b0;
      bytes_left    <= '0;
      target_kind   <= '0;
      value_accum   <= '0;
      search_status <= tof_pkg::ST_NONE;
      res_valid     <= 1'b0;
    end else begin
      // A result is loaded by a last byte and held until it is taken
      res_valid <= (item_take && item.last_byte) || (res_valid && !res_ready);
      if (item_take) begin
        target_kind <= target_kind_next;
        if (item.last_byte) begin
          phase         <= PH_KIND;
          area_offset   <= '0;
          kind_hit      <= 1'b0;
          bytes_left    <= '0;
          value_accum   <= '0;
          search_status <= tof_pkg::ST_NONE;
        end else begin
          phase         <= phase_next;
          area_offset   <= area_offset_next;
          kind_hit      <= kind_hit_next;
          bytes_left    <= bytes_left_next;
          value_accum   <= value_accum_next;
          search_status <= search_status_next;
        end
      end
    end
    if (item_take && item.last_byte) begin
      res_status <= search_status_next;
      res_value  <= (search_status_next == tof_pkg::ST_DATA) ? 64'(value_accum_next) : '0;
    end
  end

  // Checks
  `TOF_ASSERT_NOW(a_status_done, search_status != tof_pkg::ST_NONE, phase == PH_DONE, "status set while walk still open")
  `TOF_ASSERT_NOW(a_hit_kind, kind_hit, target_kind > 8'd1, "hit flagged for a one-byte kind")
  `TOF_ASSERT_NOW(a_offset_max, 1'b1, area_offset <= OFFSET_W'(MAX_OPTION_BYTES), "area offset past limit")
  `TOF_ASSERT_NEXT(a_last_result, item_take && item.last_byte, res_valid, "last byte gave no result")
  `TOF_ASSERT_NOW(a_value_zero, res_valid && res_status != tof_pkg::ST_DATA, res_value == 64'd0, "value without data status")

endmodule

// ===== sv/tcp_option_finder.sv =====
// ----------------------------------------------------------------------------
// tcp_option_finder
// Finds the first TCP option of a wanted kind in a byte stream of the
// option area and reports its status and big-endian data value.
//
//   Channel   Dir   Handshake                     Contents
//   s_axis    in    s_axis_tvalid/s_axis_tready   one option byte + markers
//   m_axis    out   m_axis_tvalid/m_axis_tready   status and value per area
//
// One byte per cycle while the result register can take a result; a byte
// is registered in the input stage and parsed from there, and a result is
// registered in the cycle after the last byte is parsed, one walk step per byte.
// A last byte waits in the input register while the result register is full.
// rst is synchronous, active high, and returns the walker to a kind byte.
// ----------------------------------------------------------------------------
module tcp_option_finder #(
  parameter int MAX_OPTION_BYTES = tof_pkg::MAX_OPTION_BYTES,
  parameter int VALUE_BITS       = tof_pkg::VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  input  logic [8:0]  s_axis_tuser,   // [0] first_byte, [8:1] wanted_kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] option_value
  output logic [1:0]  m_axis_tuser    // [1:0] find_status
);

  tof_pkg::item_t s_item;
  tof_pkg::item_t item;
  logic           item_valid;
  logic           item_take;

  // Gather the slave-side fields
  always_comb begin
    s_item.data_byte   = s_axis_tdata;
    s_item.first_byte  = s_axis_tuser[0];
    s_item.last_byte   = s_axis_tlast;
    s_item.wanted_kind = s_axis_tuser[8:1];
  end

  tof_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_item     (s_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  tof_parser #(
    .MAX_OPTION_BYTES (MAX_OPTION_BYTES),
    .VALUE_BITS       (VALUE_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_status (m_axis_tuser),
    .res_value  (m_axis_tdata)
  );

endmodule
